// File: hw/rtl/cxbr_pkg.sv
// Shared types and constants for the combined xorshift / BBS random word generator.
`timescale 1ns / 1ps
`default_nettype none

package cxbr_pkg;

	localparam int unsigned XS_W  = 64;
	localparam int unsigned BBS_W = 32;
	localparam int unsigned SQ_W  = 2 * BBS_W;

	// Bits of the square folded into the remainder per reduction cycle.
	localparam int unsigned RED_BITS_PER_CYC = 2;
	localparam int unsigned RED_CYCLES       = SQ_W / RED_BITS_PER_CYC;
	localparam int unsigned RED_CNT_W        = $clog2(RED_CYCLES);

	typedef struct packed {
		logic             start;
		logic [BBS_W-1:0] operand;
		logic [BBS_W-1:0] modulus;
	} modsq_req_t;

	typedef struct packed {
		logic             done;
		logic [BBS_W-1:0] result;
	} modsq_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/cxbr_modsq.sv
// Iterative modular square unit: one multiply, then restoring reduction two bits a cycle.
`timescale 1ns / 1ps
`default_nettype none

module cxbr_modsq
	import cxbr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire modsq_req_t req,
	output modsq_rsp_t      rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_RED  = 2'd2;

	logic [1:0]           state_q;
	logic [BBS_W-1:0]     op_q;
	logic [BBS_W-1:0]     mod_q;
	logic [SQ_W-1:0]      prod_q;
	logic [BBS_W-1:0]     rem_q;
	logic [RED_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [BBS_W-1:0]     result_q;

	logic [SQ_W-1:0]      prod_w;
	logic [BBS_W-1:0]     rem_next;

	assign prod_w = SQ_W'(op_q) * SQ_W'(op_q);

	// Two restoring steps: shift in the next bit of the square, subtract if it fits.
	always_comb begin
		logic [BBS_W:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < RED_BITS_PER_CYC; i++) begin
			r = {r[BBS_W-1:0], prod_q[SQ_W-1-i]};
			if (r >= {1'b0, mod_q}) begin
				r = r - {1'b0, mod_q};
			end
		end
		rem_next = r[BBS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (req.start) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q <= '0;
					if (mod_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						done_q  <= 1'b0;
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == RED_CNT_W'(RED_CYCLES - 1)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						done_q  <= 1'b0;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					op_q  <= req.operand;
					mod_q <= req.modulus;
				end
			end
			ST_MUL: begin
				prod_q   <= prod_w;
				rem_q    <= '0;
				result_q <= prod_w[BBS_W-1:0];
			end
			ST_RED: begin
				prod_q   <= {prod_q[SQ_W-RED_BITS_PER_CYC-1:0], {RED_BITS_PER_CYC{1'b0}}};
				rem_q    <= rem_next;
				result_q <= rem_next;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

	// A reduced result is always below a nonzero modulus.
	a_result_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (mod_q != '0) |-> result_q < mod_q)
		else $error("modular square result not reduced");

	// The unit is only started while it is free.
	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == ST_IDLE)
		else $error("modular square started while busy");

	// A finish follows the last reduction cycle.
	a_done_after_red: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RED) && (cnt_q == RED_CNT_W'(RED_CYCLES - 1)) |=> done_q)
		else $error("modular square did not finish after reduction");

endmodule

`default_nettype wire

// File: hw/rtl/combined_xorshift_bbs_rng.sv
// Top level of the combined xorshift / Blum-Blum-Shub random word generator.
// An accepted item is squared in the modular square unit (one multiply, then the reduction
// two bits of the square at a time, skipped when the modulus is zero), waits in the finish
// state until the output register is free, and then raises out_valid with its random_word.
// The block takes no new item until the last one has entered the output register.
// in_stall stays high from acceptance until the result enters the output register.
// Reset (arst_n, asynchronous, active low) loads the register defaults and the seeded state.
`timescale 1ns / 1ps
`default_nettype none

module combined_xorshift_bbs_rng
	import cxbr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration write port.
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [XS_W-1:0]   cfg_data,
	// Request channel.
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              reseed,
	// Result channel.
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [BBS_W-1:0]       random_word
);

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_VARIANT     = 3'd0;
	localparam logic [2:0] REG_SEED_A      = 3'd1;
	localparam logic [2:0] REG_SEED_B      = 3'd2;
	localparam logic [2:0] REG_SEED_C      = 3'd3;
	localparam logic [2:0] REG_BBS_SEED    = 3'd4;
	localparam logic [2:0] REG_BBS_MODULUS = 3'd5;

	// Register defaults after reset.
	localparam logic [XS_W-1:0]  RST_SEED_A   = 64'd11234525;
	localparam logic [XS_W-1:0]  RST_SEED_B   = 64'd453264536;
	localparam logic [XS_W-1:0]  RST_SEED_C   = 64'd89804324;
	localparam logic [BBS_W-1:0] RST_BBS_SEED = 32'd231423;
	localparam logic [BBS_W-1:0] RST_BBS_MOD  = 32'd4292870399;
	localparam logic [BBS_W-1:0] MIX_INIT     = 32'd1;

	// Sequencer states.
	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_WAIT = 2'd1;
	localparam logic [1:0] T_FIN  = 2'd2;

	// One xorshift round: left, logical right, left.
	function automatic logic [XS_W-1:0] xs_round(input logic [XS_W-1:0] v,
	                                             input int unsigned l1,
	                                             input int unsigned r,
	                                             input int unsigned l2);
		logic [XS_W-1:0] t;
		t = v ^ (v << l1);
		t = t ^ (t >> r);
		t = t ^ (t << l2);
		return t;
	endfunction

	logic             variant_q;
	logic [XS_W-1:0]  seed_a_q;
	logic [XS_W-1:0]  seed_b_q;
	logic [XS_W-1:0]  seed_c_q;
	logic [BBS_W-1:0] bbs_seed_q;
	logic [BBS_W-1:0] bbs_mod_q;

	logic [XS_W-1:0]  xs_a_q;
	logic [XS_W-1:0]  xs_b_q;
	logic [XS_W-1:0]  xs_c_q;
	logic [BBS_W-1:0] bbs_q;
	logic [BBS_W-1:0] mix_q;

	logic [1:0]       state_q;
	logic             out_valid_q;
	logic [BBS_W-1:0] out_word_q;

	logic             in_accept;
	logic             out_free;
	logic [XS_W-1:0]  src_a;
	logic [XS_W-1:0]  src_b;
	logic [XS_W-1:0]  src_c;
	logic [BBS_W-1:0] src_bbs;
	logic [BBS_W-1:0] src_mix;
	logic [BBS_W-1:0] mix_next;

	modsq_req_t       sq_req;
	modsq_rsp_t       sq_rsp;

	assign in_stall  = (state_q != T_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// A reseed item starts from the seed registers instead of the running state.
	assign src_a   = reseed ? seed_a_q   : xs_a_q;
	assign src_b   = reseed ? seed_b_q   : xs_b_q;
	assign src_c   = reseed ? seed_c_q   : xs_c_q;
	assign src_bbs = reseed ? bbs_seed_q : bbs_q;
	assign src_mix = reseed ? MIX_INIT   : mix_q;

	assign sq_req.start   = in_accept;
	assign sq_req.operand = src_bbs;
	assign sq_req.modulus = bbs_mod_q;

	cxbr_modsq u_modsq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	// Mix generator halves into the mix word; the low bits of the new BBS value select the optional ones.
	always_comb begin
		logic [BBS_W-1:0] s;
		s = mix_q;
		if (!variant_q) begin
			if (bbs_q[0]) s = s ^ xs_a_q[XS_W-1:BBS_W];
			s = s ^ xs_a_q[BBS_W-1:0];
			if (bbs_q[1]) s = s ^ xs_b_q[XS_W-1:BBS_W];
			s = s ^ xs_b_q[BBS_W-1:0];
			if (bbs_q[2]) s = s ^ xs_c_q[XS_W-1:BBS_W];
			s = s ^ xs_c_q[BBS_W-1:0];
		end else begin
			if (bbs_q[0]) s = s ^ xs_a_q[XS_W-1:BBS_W];
			if (bbs_q[1]) s = s ^ xs_a_q[BBS_W-1:0];
			if (bbs_q[2]) s = s ^ xs_b_q[XS_W-1:BBS_W];
			s = s ^ xs_b_q[BBS_W-1:0];
		end
		mix_next = s;
	end

	// Configuration registers. Seed writes only matter at the next reseed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q  <= 1'b1;
			seed_a_q   <= RST_SEED_A;
			seed_b_q   <= RST_SEED_B;
			seed_c_q   <= RST_SEED_C;
			bbs_seed_q <= RST_BBS_SEED;
			bbs_mod_q  <= RST_BBS_MOD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VARIANT:     variant_q  <= cfg_data[0];
				REG_SEED_A:      seed_a_q   <= cfg_data;
				REG_SEED_B:      seed_b_q   <= cfg_data;
				REG_SEED_C:      seed_c_q   <= cfg_data;
				REG_BBS_SEED:    bbs_seed_q <= cfg_data[BBS_W-1:0];
				REG_BBS_MODULUS: bbs_mod_q  <= cfg_data[BBS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Generator state and sequencer. The xorshift rounds are cheap and finish at
	// acceptance; the BBS square runs in the modular square unit while the block waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
			xs_a_q      <= RST_SEED_A;
			xs_b_q      <= RST_SEED_B;
			xs_c_q      <= RST_SEED_C;
			bbs_q       <= RST_BBS_SEED;
			mix_q       <= MIX_INIT;
		end else begin
			// A finished item fills the output register; otherwise a taken result empties it.
			if ((state_q == T_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (in_accept) begin
						xs_a_q  <= xs_round(src_a, 13, 35, 30);
						xs_b_q  <= xs_round(src_b, 23, 13, 58);
						xs_c_q  <= variant_q ? src_c : xs_round(src_c, 31, 25, 37);
						mix_q   <= src_mix;
						state_q <= T_WAIT;
					end
				end
				T_WAIT: begin
					if (sq_rsp.done) begin
						bbs_q   <= sq_rsp.result;
						state_q <= T_FIN;
					end
				end
				T_FIN: begin
					if (out_free) begin
						mix_q   <= mix_next;
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == T_FIN) && out_free) begin
			out_word_q <= mix_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

	// An accepted item always starts the square unit and waits on it.
	a_accept_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == T_WAIT)
		else $error("accepted item did not enter the wait state");

	// The square unit only reports while an item waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_rsp.done |-> state_q == T_WAIT)
		else $error("square result arrived with no item waiting");

	// Finishing an item always presents a result and frees the request side.
	a_fin_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_FIN) && out_free |=> out_valid_q && (state_q == T_IDLE))
		else $error("finished item was not presented");

	// A result is never overwritten while it waits to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !((state_q == T_FIN) && out_free))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: verif/cxbr_tb_pkg.sv
// Register indexes and combine codes shared by the testbench files of the random word generator.
`timescale 1ns / 1ps

package cxbr_tb_pkg;

	typedef enum logic [2:0] {
		REG_VARIANT     = 3'd0,
		REG_SEED_A      = 3'd1,
		REG_SEED_B      = 3'd2,
		REG_SEED_C      = 3'd3,
		REG_BBS_SEED    = 3'd4,
		REG_BBS_MODULUS = 3'd5,
		REG_SPARE_6     = 3'd6,
		REG_SPARE_7     = 3'd7
	} cfg_reg_e;

	localparam logic COMBINE_THREE = 1'b0;
	localparam logic COMBINE_TWO   = 1'b1;

endpackage

// File: verif/cxbr_checker.sv
// Watches the generator's ports, predicts every random word and compares it with the output.
`timescale 1ns / 1ps

module cxbr_checker
	import cxbr_pkg::*;
	import cxbr_tb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [XS_W-1:0]  cfg_data,
	input  wire logic             in_valid,
	input  wire logic             in_stall,
	input  wire logic             reseed,
	input  wire logic             out_valid,
	input  wire logic             out_stall,
	input  wire logic [BBS_W-1:0] random_word,
	output int                    fail_count,
	output int                    pending_count
);

	logic             variant_q;
	logic [XS_W-1:0]  seed_a_q, seed_b_q, seed_c_q;
	logic [BBS_W-1:0] bbs_seed_q, modulus_q;
	logic [XS_W-1:0]  xs_a, xs_b, xs_c;
	logic [BBS_W-1:0] bbs_q, mix_q;
	logic [BBS_W-1:0] word_q[$];
	int               errors;

	function automatic logic [XS_W-1:0] xorshift(input logic [XS_W-1:0] v,
		input int unsigned l1, input int unsigned r, input int unsigned l2);
		v ^= v << l1;
		v ^= v >> r;
		v ^= v << l2;
		return v;
	endfunction

	task automatic load_seeds();
		xs_a  = seed_a_q;
		xs_b  = seed_b_q;
		xs_c  = seed_c_q;
		bbs_q = bbs_seed_q;
		mix_q = 32'd1;
	endtask

	// One generator step; returns the new mix word.
	task automatic advance(input logic reload, output logic [BBS_W-1:0] word);
		logic [SQ_W-1:0]  sq;
		logic [BBS_W-1:0] s;
		if (reload) begin
			load_seeds();
		end
		xs_a = xorshift(xs_a, 13, 35, 30);
		xs_b = xorshift(xs_b, 23, 13, 58);
		if (variant_q == COMBINE_THREE) begin
			xs_c = xorshift(xs_c, 31, 25, 37);
		end
		sq = SQ_W'(bbs_q) * SQ_W'(bbs_q);
		if (modulus_q != '0) begin
			sq = sq % SQ_W'(modulus_q);
		end
		bbs_q = sq[BBS_W-1:0];
		s = mix_q;
		if (variant_q == COMBINE_THREE) begin
			if (bbs_q[0]) s ^= xs_a[63:32];
			s ^= xs_a[31:0];
			if (bbs_q[1]) s ^= xs_b[63:32];
			s ^= xs_b[31:0];
			if (bbs_q[2]) s ^= xs_c[63:32];
			s ^= xs_c[31:0];
		end else begin
			if (bbs_q[0]) s ^= xs_a[63:32];
			if (bbs_q[1]) s ^= xs_a[31:0];
			if (bbs_q[2]) s ^= xs_b[63:32];
			s ^= xs_b[31:0];
		end
		mix_q = s;
		word = s;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [BBS_W-1:0] word;
		logic [BBS_W-1:0] exp_word;
		if (!arst_n) begin
			variant_q  = COMBINE_TWO;
			seed_a_q   = 64'd11234525;
			seed_b_q   = 64'd453264536;
			seed_c_q   = 64'd89804324;
			bbs_seed_q = 32'd231423;
			modulus_q  = 32'd4292870399;
			load_seeds();
			word_q.delete();
			errors = 0;
			pending_count <= 0;
			fail_count    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_e'(cfg_index))
					REG_VARIANT:     variant_q  = cfg_data[0];
					REG_SEED_A:      seed_a_q   = cfg_data;
					REG_SEED_B:      seed_b_q   = cfg_data;
					REG_SEED_C:      seed_c_q   = cfg_data;
					REG_BBS_SEED:    bbs_seed_q = cfg_data[BBS_W-1:0];
					REG_BBS_MODULUS: modulus_q  = cfg_data[BBS_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (word_q.size() == 0) begin
					$error("random_word: unexpected item, actual %h", random_word);
					errors++;
				end else begin
					exp_word = word_q.pop_front();
					if (random_word !== exp_word) begin
						$error("random_word: expected %h, actual %h", exp_word, random_word);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				advance(reseed, word);
				word_q.push_back(word);
			end
			pending_count <= word_q.size();
			fail_count    <= errors;
		end
	end

endmodule

// File: verif/tb_top.sv
// Stimulus and verdict for the combined xorshift / Blum-Blum-Shub random word generator.
`timescale 1ns / 1ps

module tb_top;

	import cxbr_pkg::*;
	import cxbr_tb_pkg::*;

	// Far above the slowest correct run: about 1500 items, each through the square unit,
	// plus sender gaps, receiver stalls and the long hold-offs.
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RAND_PHASES   = 15;
	localparam int PHASE_ITEMS   = 100;
	// The long receiver hold-off starts once this many items have gone in, which
	// falls in the middle of a random phase so the sender keeps offering items.
	localparam int HOLD_AT_ITEM  = 250;
	localparam int HOLD_CYCLES   = 600;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [2:0]       cfg_index;
	logic [XS_W-1:0]  cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic             reseed;
	logic             out_valid;
	logic             out_stall;
	logic [BBS_W-1:0] random_word;
	int               fail_count;
	int               pending_count;
	int               items_sent;

	combined_xorshift_bbs_rng DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.reseed      (reseed),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word)
	);

	// The checker sees exactly the port traffic that the block sees, keeps its own copy of
	// the registers and the generator state, and reports failures and outstanding words.
	cxbr_checker u_word_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.reseed        (reseed),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.random_word   (random_word),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Every task below is entered right after a rising edge and drives with nonblocking
	// assignments, so the block samples the new values at the following edge.

	// One register write; the caller lowers the write enable after its last write.
	task automatic write_reg(input cfg_reg_e idx, input logic [XS_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one item and returns at the edge where it is accepted. The valid stays
	// high, so back-to-back calls form a burst without a bubble.
	task automatic send_item(input logic rs);
		in_valid <= 1'b1;
		reseed   <= rs;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Stops offering and waits until every predicted word has come out. The first edge
	// is needed because the checker's count only rises after the accepting edge.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [XS_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Seeds lean toward the extremes and small values, which are where the xorshift
	// and the squaring step are most likely to go wrong.
	function automatic logic [XS_W-1:0] pick_seed();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return XS_W'($urandom_range(0, 255));
			default: return rand64();
		endcase
	endfunction

	// The modulus stays within its legal range; the upper data bits carry noise that
	// the block has to drop.
	function automatic logic [XS_W-1:0] pick_modulus();
		logic [BBS_W-1:0] m;
		case ($urandom_range(0, 5))
			0:       m = 32'd3;
			1:       m = '1;
			2:       m = BBS_W'($urandom_range(3, 1000));
			default: begin
				m = $urandom();
				if (m < 3) m = 32'd3;
			end
		endcase
		return {$urandom(), m};
	endfunction

	// The receiver runs on its own pattern of free stretches, random stalls, stall
	// bursts and toggling. Once, mid-run, it holds off long enough for the block to
	// fill its output register and push back on the sender.
	initial begin : receiver
		int  sel;
		int  n;
		bit  hold_done;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			sel = $urandom_range(0, 39);
			if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (sel == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(200, 400)) @(posedge clk);
			end else if (sel < 16) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(10, 150)) @(posedge clk);
			end else if (sel < 28) begin
				n = $urandom_range(20, 100);
				repeat (n) begin
					out_stall <= ($urandom_range(0, 3) == 0);
					@(posedge clk);
				end
			end else if (sel < 36) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				n = $urandom_range(4, 40);
				repeat (n) begin
					out_stall <= ~out_stall;
					@(posedge clk);
				end
			end
		end
	end

	// A hung block shows up here rather than as a silent hang.
	initial begin : watchdog
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin : stimulus
		int  burst_left;
		int  gap;
		logic rs;
		items_sent = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		reseed    <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Reset defaults: the state after reset must already be seeded, and a reseed
		// item must bring the sequence back to its very first word.
		send_item(1'b0);
		send_item(1'b0);
		send_item(1'b0);
		send_item(1'b1);
		send_item(1'b0);
		drain();

		// A new seed must not touch the running state until an item asks for a reseed.
		write_reg(REG_SEED_A, rand64());
		end_writes();
		send_item(1'b0);
		send_item(1'b1);
		drain();

		// Three-generator combine with every seed and the modulus at their maximum.
		write_reg(REG_VARIANT, {{(XS_W-1){1'b0}}, COMBINE_THREE});
		write_reg(REG_SEED_A, '1);
		write_reg(REG_SEED_B, '1);
		write_reg(REG_SEED_C, '1);
		write_reg(REG_BBS_SEED, 64'hFFFF_FFFF);
		write_reg(REG_BBS_MODULUS, 64'hFFFF_FFFF);
		end_writes();
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b0);
		drain();

		// All-zero xorshift state must stay at zero; a zero modulus keeps the raw
		// low half of the square.
		write_reg(REG_SEED_A, '0);
		write_reg(REG_SEED_B, '0);
		write_reg(REG_SEED_C, '0);
		write_reg(REG_BBS_SEED, 64'hDEAD_BEEF);
		write_reg(REG_BBS_MODULUS, '0);
		end_writes();
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b0);
		drain();

		// A BBS seed far above the smallest modulus is reduced by the first squaring.
		write_reg(REG_VARIANT, {{(XS_W-1){1'b0}}, COMBINE_TWO});
		write_reg(REG_SEED_A, rand64());
		write_reg(REG_SEED_B, rand64());
		write_reg(REG_BBS_SEED, 64'hFFFF_FFFF);
		write_reg(REG_BBS_MODULUS, 64'd3);
		end_writes();
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b0);
		drain();

		// Writes to the unused indexes must leave every register alone.
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		write_reg(REG_VARIANT, {{(XS_W-1){1'b0}}, COMBINE_THREE});
		end_writes();
		send_item(1'b0);
		send_item(1'b0);
		drain();

		// Upper data bits on the narrow registers must be ignored.
		write_reg(REG_VARIANT, '1);
		write_reg(REG_SEED_A, rand64());
		write_reg(REG_SEED_B, rand64());
		write_reg(REG_SEED_C, rand64());
		write_reg(REG_BBS_SEED, {32'hFFFF_FFFF, 32'h0001_0001});
		write_reg(REG_BBS_MODULUS, {32'hFFFF_FFFF, 32'd1000003});
		end_writes();
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b0);
		drain();

		// Random phases: a fresh mix of register writes while idle, then items in bursts
		// with random gaps. Reseeds are sparse so the generators run long sequences.
		burst_left = $urandom_range(1, 12);
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_reg(REG_VARIANT, {(XS_W-1)'(rand64()), 1'($urandom_range(0, 1))});
			if ($urandom_range(0, 1) != 0) write_reg(REG_SEED_A, pick_seed());
			if ($urandom_range(0, 1) != 0) write_reg(REG_SEED_B, pick_seed());
			if ($urandom_range(0, 1) != 0) write_reg(REG_SEED_C, pick_seed());
			if ($urandom_range(0, 1) != 0) write_reg(REG_BBS_SEED, pick_seed());
			if ($urandom_range(0, 1) != 0) write_reg(REG_BBS_MODULUS, pick_modulus());
			if ($urandom_range(0, 7) == 0) begin
				write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_7 : REG_SPARE_6, rand64());
			end
			end_writes();
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == 0) rs = 1'($urandom_range(0, 1));
				else        rs = ($urandom_range(0, 15) == 0);
				send_item(rs);
				burst_left--;
				if (burst_left == 0) begin
					// Now and then a long burst with no gaps at all.
					burst_left = ($urandom_range(0, 7) == 0) ? 50 : $urandom_range(1, 12);
					gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
					if (gap > 0) begin
						in_valid <= 1'b0;
						reseed   <= 1'($urandom_range(0, 1));
						repeat (gap) @(posedge clk);
					end
				end
			end
			drain();
		end

		// Give the block time to show any word that it should not produce.
		repeat (80) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
